// ===== hw/rtl/frc_pkg.sv =====
// Shared types and constants of the field reversal controller.
// Used by the channel interfaces, the control core and the top level.
// No dependencies.
package frc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // Position of the binary point of the flux gain.
    localparam int GAIN_FRAC  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARM_CURRENT_LIMIT = 3'd0,
        REG_FLUX_GAIN         = 3'd1,
        REG_MIN_FIELD_CURRENT = 3'd2,
        REG_POS_SPEED_LIMIT   = 3'd3,
        REG_NEG_SPEED_LIMIT   = 3'd4,
        REG_REVERSAL_ENABLE   = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_POS  = 2'd1,
        CLAMP_NEG  = 2'd2
    } t_clamp;

    typedef struct packed {
        logic        [15:0] armature_current_limit;
        logic signed [15:0] flux_gain;
        logic        [14:0] min_field_current;
        logic signed [15:0] pos_speed_limit;
        logic signed [15:0] neg_speed_limit;
        logic               reversal_enable;
    } t_cfg;

    typedef struct packed {
        logic        [15:0] armature_current;
        logic signed [15:0] field_current;
        logic signed [31:0] speed_reg_wide;
        logic signed [15:0] speed_reg_out;
        logic               speed_reg_active;
        logic        [15:0] timer_now;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] flux_command;
        logic signed [15:0] speed_out;
        logic               direction;
        logic               reversing;
        logic               low_field_current;
        logic               reversal_overdue;
        logic               reversal_permitted;
        logic               field_current_negative;
        t_clamp             clamp_hit;
        logic               msg_current_not_zero;
        logic               msg_field_not_reversed;
        logic               msg_reversal_fault;
    } t_out_item;

    typedef struct packed {
        logic               field_direction;
        logic               overdue_flag;
        logic        [15:0] reversal_start_time;
        logic               reversal_active;
        logic               low_current_flag;
        logic signed [15:0] held_flux_command;
    } t_state;

endpackage

// ===== hw/rtl/frc_if.sv =====
// Valid/ready channel interfaces of the field reversal controller.
// Depends on frc_pkg for the payload types.
interface frc_in_if;
    import frc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface frc_out_if;
    import frc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface frc_cfg_if;
    import frc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/field_reversal_controller_unit.sv =====
// Field reversal controller, top level.
// A request accepted into the input stage passes frc_core into the result register.
// Throughput: one request per cycle while o_out is not stalled, set by the loop that
// feeds the controller state from the output of frc_core back into the next tick.
// Reset (i_rst_n, synchronous, active low) clears the controller state, the
// configuration registers and both pipeline stages.
module field_reversal_controller_unit #(
    parameter int FLUX_NOMINAL     = 4096,
    parameter int FLUX_MARGIN      = 82,
    parameter int REVERSAL_TIMEOUT = 2000
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frc_in_if.sink     i_in,
    frc_out_if.source  o_out,
    frc_cfg_if.sink    i_cfg
);
    import frc_pkg::*;

    // Configuration registers. Writes are only expected while the block is
    // idle, so they are always accepted.
    t_cfg      r_cfg;

    // Input stage: holds one request until the result register can take it.
    logic      r_in_vld;
    t_in_item  r_in;

    // Controller state carried from one tick to the next.
    t_state    r_state;
    t_state    n_state;

    // Result register, which parts the output handshake from the input side.
    logic      r_out_vld;
    t_out_item r_out;
    t_out_item n_out;

    logic      w_advance;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ARM_CURRENT_LIMIT: r_cfg.armature_current_limit <= i_cfg.data;
                REG_FLUX_GAIN:         r_cfg.flux_gain              <= i_cfg.data;
                REG_MIN_FIELD_CURRENT: r_cfg.min_field_current      <= i_cfg.data[14:0];
                REG_POS_SPEED_LIMIT:   r_cfg.pos_speed_limit        <= i_cfg.data;
                REG_NEG_SPEED_LIMIT:   r_cfg.neg_speed_limit        <= i_cfg.data;
                REG_REVERSAL_ENABLE:   r_cfg.reversal_enable        <= i_cfg.data[0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    // The held request moves into the result register whenever that
    // register is empty or is being emptied in the same cycle. The state is
    // updated at the same edge, so the next request sees it at once.
    assign w_advance  = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_advance;

    frc_core #(
        .FLUX_NOMINAL     (FLUX_NOMINAL),
        .FLUX_MARGIN      (FLUX_MARGIN),
        .REVERSAL_TIMEOUT (REVERSAL_TIMEOUT)
    ) u_core (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_item  (n_out),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (w_advance) begin
                r_in_vld <= 1'b0;
            end
            if (w_advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers need no reset; their valid flags guard them.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    // A timeout fault always leaves the overdue flag set in the same result.
    a_fault_sets_overdue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.msg_reversal_fault |-> r_out.reversal_overdue)
        else $error("reversal fault reported without the overdue flag");

    // The field-not-reversed message only appears during a reversal.
    a_field_msg_in_reversal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.msg_field_not_reversed |-> r_out.reversing)
        else $error("field-not-reversed message outside a reversal");

    // The field direction only changes when a request passes the core.
    a_direction_moves_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_state.field_direction != $past(r_state.field_direction))
        |-> $past(w_advance))
        else $error("field direction changed without a control tick");

    // With the result register empty the input side must be open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_in.ready)
        else $error("input stalled while the result register is empty");
`endif

endmodule

// ===== hw/rtl/frc_core.sv =====
// Combinational control step of the field reversal controller: one tick.
// Depends on frc_pkg for the configuration, item and state types.
module frc_core #(
    parameter int FLUX_NOMINAL     = 4096,
    parameter int FLUX_MARGIN      = 82,
    parameter int REVERSAL_TIMEOUT = 2000
) (
    input  frc_pkg::t_cfg      i_cfg,
    input  frc_pkg::t_state    i_state,
    input  frc_pkg::t_in_item  i_item,
    output frc_pkg::t_out_item o_item,
    output frc_pkg::t_state    o_state
);
    import frc_pkg::*;

    localparam logic signed [16:0] L_NOM     = 17'(FLUX_NOMINAL);
    localparam logic signed [16:0] L_NOM_NEG = -L_NOM;
    localparam logic signed [16:0] L_MARGIN  = 17'(FLUX_MARGIN);
    localparam logic        [15:0] L_TIMEOUT = 16'(REVERSAL_TIMEOUT);

    logic signed [47:0] prod;
    logic signed [15:0] cmd_raw;
    logic signed [16:0] cmd_raw17;
    logic signed [15:0] cmd;
    logic signed [16:0] cmd17;
    logic               neg_cmd;
    logic signed [16:0] minc17;
    logic signed [16:0] nminc17;
    logic signed [16:0] iv17;
    logic signed [15:0] force_pos;
    logic signed [15:0] force_neg;
    logic        [15:0] elapsed;
    logic               permitted;

    assign prod      = i_item.speed_reg_wide * i_cfg.flux_gain;
    assign cmd_raw   = i_item.speed_reg_active ? prod[GAIN_FRAC+15:GAIN_FRAC] : '0;
    assign neg_cmd   = i_item.speed_reg_active & cmd_raw[15];
    assign cmd_raw17 = {cmd_raw[15], cmd_raw};

    // Limit the command to the nominal flux in either sense.
    always_comb begin
        if (cmd_raw17 > L_NOM) begin
            cmd = 16'(L_NOM);
        end else if (cmd_raw17 < L_NOM_NEG) begin
            cmd = 16'(L_NOM_NEG);
        end else begin
            cmd = cmd_raw;
        end
    end

    assign cmd17     = {cmd[15], cmd};
    assign minc17    = {2'b00, i_cfg.min_field_current};
    assign nminc17   = -minc17;
    assign iv17      = {i_item.field_current[15], i_item.field_current};
    // The forced commands wrap into 16 bits when the threshold is large.
    assign force_pos = 16'(minc17 + L_MARGIN);
    assign force_neg = 16'(nminc17 - L_MARGIN);
    assign elapsed   = i_item.timer_now - i_state.reversal_start_time;
    assign permitted = i_item.armature_current < i_cfg.armature_current_limit;

    always_comb begin
        t_state             ns;
        logic signed [15:0] fv;
        logic signed [15:0] hi;
        logic signed [15:0] lo;
        logic signed [15:0] sreg;
        logic signed [15:0] speed;
        logic signed [15:0] flux;
        t_clamp             clamp;
        logic               msg_field;
        logic               msg_fault;

        ns        = i_state;
        sreg      = i_item.speed_reg_out;
        speed     = sreg;
        flux      = i_state.held_flux_command;
        clamp     = CLAMP_NONE;
        msg_field = 1'b0;
        msg_fault = 1'b0;
        fv        = cmd;
        hi        = '0;
        lo        = '0;

        if (i_cfg.reversal_enable) begin
            ns.reversal_active = 1'b0;
            if (!i_state.field_direction && neg_cmd) begin
                ns.reversal_active = 1'b1;
                if (!permitted) begin
                    fv = '0;
                end else if (iv17 > nminc17) begin
                    fv        = force_neg;
                    msg_field = i_state.overdue_flag;
                end else begin
                    ns.field_direction = 1'b1;
                end
            end else if (i_state.field_direction && !neg_cmd) begin
                ns.reversal_active = 1'b1;
                if (!permitted) begin
                    fv = '0;
                end else if (iv17 < minc17) begin
                    fv        = force_pos;
                    msg_field = i_state.overdue_flag;
                end else begin
                    ns.field_direction = 1'b0;
                end
            end else begin
                // Steady direction: keep the field above its minimum.
                ns.low_current_flag = 1'b0;
                if (!i_state.field_direction) begin
                    if (cmd17 > minc17 && iv17 < minc17) begin
                        fv                  = force_pos;
                        ns.low_current_flag = 1'b1;
                    end
                end else begin
                    if (cmd17 < nminc17 && iv17 > nminc17) begin
                        fv                  = force_neg;
                        ns.low_current_flag = 1'b1;
                    end
                end
            end

            if (ns.reversal_active) begin
                if (elapsed > L_TIMEOUT) begin
                    msg_fault       = 1'b1;
                    ns.overdue_flag = 1'b1;
                end
            end else begin
                ns.reversal_start_time = i_item.timer_now;
                ns.overdue_flag        = 1'b0;
            end

            if (!(ns.reversal_active || ns.low_current_flag)) begin
                hi = i_cfg.pos_speed_limit;
                lo = i_cfg.neg_speed_limit;
            end

            if (!sreg[15]) begin
                if (sreg > hi) begin
                    speed = hi;
                    clamp = CLAMP_POS;
                end
            end else begin
                if (sreg < lo) begin
                    sreg  = lo;
                    clamp = CLAMP_NEG;
                end
                speed = 16'(16'd0 - sreg);
            end

            flux                 = fv;
            ns.held_flux_command = fv;
        end

        o_state                       = ns;
        o_item.flux_command           = flux;
        o_item.speed_out              = speed;
        o_item.direction              = ns.field_direction;
        o_item.reversing              = ns.reversal_active;
        o_item.low_field_current      = ns.low_current_flag;
        o_item.reversal_overdue       = ns.overdue_flag;
        o_item.reversal_permitted     = permitted;
        o_item.field_current_negative = i_item.field_current[15];
        o_item.clamp_hit              = clamp;
        o_item.msg_current_not_zero   = !permitted && i_state.overdue_flag;
        o_item.msg_field_not_reversed = msg_field;
        o_item.msg_reversal_fault     = msg_fault;
    end

endmodule
